[hdl/ffsa_pkg.sv]
// Shared types and codes for the first-fit segment allocator.
package ffsa_pkg;

  localparam int KIND_W  = 2;
  localparam int SIZE_W  = 11;
  localparam int OFFS_W  = 10;
  localparam int STAT_W  = 2;
  localparam int START_W = 10;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPACT = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] size;
    logic [OFFS_W-1:0] offset;
  } req_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [START_W-1:0] start_res;
  } rsp_item_t;

  // One unit of the pool: a segment starts here, and that segment is free.
  typedef struct packed {
    logic start;
    logic free;
  } map_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_TAIL,
    S_WR_USED,
    S_WR_SPLIT,
    S_FREE_CHK,
    S_COMPACT_SCAN,
    S_FINISH
  } alloc_state_t;

endpackage

[hdl/ffsa_map_ram.sv]
// Segment map memory with a registered read port and a clearing pass after reset.
module ffsa_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output ffsa_pkg::map_entry_t rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  ffsa_pkg::map_entry_t wr_data,
  output logic                 ready
);
  import ffsa_pkg::*;

  map_entry_t mem [DEPTH];

  logic          clr_busy;
  logic [AW-1:0] clr_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  map_entry_t    mem_wd;

  // The clearing pass owns the write port until every entry is written;
  // unit zero comes back as the single free segment.
  always_comb begin
    if (clr_busy) begin
      mem_we       = 1'b1;
      mem_wa       = clr_addr;
      mem_wd.start = (clr_addr == '0);
      mem_wd.free  = (clr_addr == '0);
    end else begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !clr_busy;

endmodule

[hdl/first_fit_segment_allocator.sv]
// First-fit segment allocator: control sequencer over the segment map memory.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   req     | in        | req_valid/req_ready  | kind, size, offset (req_item_t)
//   rsp     | out       | rsp_valid/rsp_ready  | status, start_res (rsp_item_t)
//
// Every unit of the pool has one map entry (segment start bit, free bit) in a
// single memory with one read and one write port and a registered read.
// An allocate streams the map from unit zero, one entry per cycle, and stops at
// the first free segment that is long enough; one write then marks the segment
// used, and a second write follows when a remainder is split off. A compact
// always walks the whole map and clears merged starts on the write port behind
// the reads. A free is one read and, when the unit starts a segment, one write.
// After reset a clearing pass writes all CAPACITY entries, one per cycle; no
// item is accepted until it ends. One item is worked on at a time. The result
// waits in an output register, and the block takes the next item while it
// waits; only a second finished result stalls behind an unread one.
module first_fit_segment_allocator #(
  parameter int CAPACITY = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ffsa_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ffsa_pkg::rsp_item_t rsp
);
  import ffsa_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = AW + 1;
  // Common width for lengths, sizes and offsets so every compare is exact.
  localparam int CW    = (AW + 1 > SIZE_W + 1) ? AW + 1 : SIZE_W + 1;

  alloc_state_t state, state_next;

  // Memory port signals.
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  map_entry_t    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  map_entry_t    wr_data;
  logic          ram_ready;

  // Sequencer registers.
  logic [CNT_W-1:0]  cnt;        // next unit to read during a scan
  logic              rd_pend;    // rd_data holds the entry at rd_idx
  logic [AW-1:0]     rd_idx;
  logic [SIZE_W-1:0] req_size;
  logic [AW-1:0]     tgt;        // unit addressed by a free
  logic [AW-1:0]     seg_s;      // start of the segment being walked
  logic              seg_free;
  logic              prev_free;  // compact: last segment start seen was free
  logic              split;
  logic [AW-1:0]     cut;        // start of the split-off remainder
  logic [STAT_W-1:0] res_status;
  logic [START_W-1:0] res_start;

  // Combinational helpers.
  logic          req_fire;
  logic          in_range;
  logic          scan_issue;
  logic [CW-1:0] seg_end;
  logic [CW-1:0] seg_len;
  logic [CW-1:0] size_w;
  logic [CW-1:0] cut_sum;
  logic          fit;
  logic          alloc_hit;
  logic          last_idx;
  logic          merge;
  logic          rsp_load;

  ffsa_map_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .ready   (ram_ready)
  );

  assign req_ready = (state == S_IDLE) && ram_ready;
  assign req_fire  = req_valid && req_ready;
  assign in_range  = (CW'(req.offset) < CW'(CAPACITY));

  assign scan_issue = ((state == S_ALLOC_SCAN) || (state == S_COMPACT_SCAN)) &&
                      (cnt < CNT_W'(CAPACITY));

  // A segment ends at the next start seen in the stream, or at the pool's end
  // once the stream is exhausted.
  assign seg_end   = (state == S_ALLOC_TAIL) ? CW'(CAPACITY) : CW'(rd_idx);
  assign seg_len   = seg_end - CW'(seg_s);
  assign size_w    = CW'(req_size);
  assign cut_sum   = CW'(seg_s) + size_w;
  assign fit       = seg_free && (seg_len >= size_w);
  assign alloc_hit = ((state == S_ALLOC_SCAN) && rd_pend && rd_data.start && fit) ||
                     ((state == S_ALLOC_TAIL) && fit);
  assign last_idx  = (rd_idx == AW'(CAPACITY - 1));

  // A free segment that directly follows a free segment loses its start.
  assign merge = (state == S_COMPACT_SCAN) && rd_pend && rd_data.start &&
                 rd_data.free && prev_free;

  assign rsp_load = (state == S_FINISH) && (!rsp_valid || rsp_ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          unique case (req.kind)
            KIND_ALLOC:   state_next = (req.size == '0) ? S_FINISH : S_ALLOC_SCAN;
            KIND_FREE:    state_next = in_range ? S_FREE_CHK : S_FINISH;
            KIND_COMPACT: state_next = S_COMPACT_SCAN;
            default:      state_next = S_FINISH;
          endcase
        end
      end
      S_ALLOC_SCAN: begin
        if (alloc_hit) begin
          state_next = S_WR_USED;
        end else if (rd_pend && last_idx) begin
          state_next = S_ALLOC_TAIL;
        end
      end
      S_ALLOC_TAIL:   state_next = alloc_hit ? S_WR_USED : S_FINISH;
      S_WR_USED:      state_next = split ? S_WR_SPLIT : S_FINISH;
      S_WR_SPLIT:     state_next = S_FINISH;
      S_FREE_CHK:     state_next = S_FINISH;
      S_COMPACT_SCAN: begin
        if (rd_pend && last_idx) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default:        state_next = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = '0;
    unique case (state)
      S_IDLE: begin
        rd_en   = req_fire && (req.kind == KIND_FREE) && in_range;
        rd_addr = AW'(req.offset);
      end
      S_ALLOC_SCAN: begin
        rd_en = scan_issue;
      end
      S_COMPACT_SCAN: begin
        rd_en   = scan_issue;
        wr_en   = merge;
        wr_addr = rd_idx;
      end
      S_WR_USED: begin
        wr_en         = 1'b1;
        wr_addr       = seg_s;
        wr_data.start = 1'b1;
      end
      S_WR_SPLIT: begin
        wr_en         = 1'b1;
        wr_addr       = cut;
        wr_data.start = 1'b1;
        wr_data.free  = 1'b1;
      end
      S_FREE_CHK: begin
        wr_en         = rd_data.start;
        wr_addr       = tgt;
        wr_data.start = 1'b1;
        wr_data.free  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    if (req_fire) begin
      req_size   <= req.size;
      tgt        <= AW'(req.offset);
      cnt        <= '0;
      seg_s      <= '0;
      seg_free   <= 1'b0;
      prev_free  <= 1'b0;
      res_start  <= '0;
      if ((req.kind == KIND_ALLOC) && (req.size == '0)) begin
        res_status <= STAT_NO_SPACE;
      end else if ((req.kind == KIND_FREE) && !in_range) begin
        res_status <= STAT_NOT_FOUND;
      end else begin
        res_status <= STAT_OK;
      end
    end
    if (scan_issue) begin
      cnt <= cnt + 1'b1;
    end
    if ((state == S_ALLOC_SCAN) && rd_pend && rd_data.start && !fit) begin
      seg_s    <= rd_idx;
      seg_free <= rd_data.free;
    end
    if (alloc_hit) begin
      res_start  <= START_W'(seg_s);
      res_status <= STAT_OK;
      split      <= (seg_len > size_w);
      cut        <= cut_sum[AW-1:0];
    end else if (state == S_ALLOC_TAIL) begin
      res_status <= STAT_NO_SPACE;
    end
    if ((state == S_FREE_CHK) && !rd_data.start) begin
      res_status <= STAT_NOT_FOUND;
    end
    if ((state == S_COMPACT_SCAN) && rd_pend && rd_data.start && !merge) begin
      prev_free <= rd_data.free;
    end
    if (rsp_load) begin
      rsp.status    <= res_status;
      rsp.start_res <= res_start;
    end
  end

  // The read and write ports never touch the same entry in one cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("map read and write hit the same entry");

  // No scan read is still in flight when the sequencer is back at rest.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rd_pend)
    else $error("stale map read pending in idle");

  // Unit zero always begins a segment, so compact never clears its start.
  a_merge_not_zero: assert property (@(posedge clk) disable iff (rst)
    merge |-> (rd_idx != '0))
    else $error("compact tried to merge unit zero");

  // A split remainder lies strictly above the segment it came from.
  a_split_above: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_SPLIT) |-> (cut > seg_s))
    else $error("split point not above segment start");

  // A nonzero start offset is only ever reported with a successful allocate.
  a_start_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.status == STAT_OK) || (rsp.start_res == '0)))
    else $error("start offset reported with a failing status");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the first-fit segment allocator, with a pool predictor.
module tb;
  import ffsa_pkg::*;

  // The pool size must match the instance below. Kind 3 has no operation
  // assigned; the block must answer it as a harmless no-op.
  localparam int CAPACITY = 1024;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Idle draws on both channels run from zero to this many cycles per item.
  localparam int MAX_IDLE = 13;

  // The slowest single operation walks the whole map and then writes to it.
  // The final settle time and the timeout are both sized from it.
  localparam int OP_CYCLES = CAPACITY + 8;
  localparam int SETTLE_CYCLES = OP_CYCLES + 64;
  localparam longint CYCLE_LIMIT = 5 * (640 * (OP_CYCLES + 2 * MAX_IDLE) + 2 * CAPACITY);

  localparam int RANDOM_ITEMS = 560;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  // Predicted pool: one start bit and one free bit per unit, exactly as the
  // block keeps them. The free bit is only meaningful where a start is set.
  bit unit_is_start [CAPACITY];
  bit unit_is_free  [CAPACITY];

  // Responses predicted at acceptance time, oldest first.
  rsp_item_t awaited_rsp [$];
  rsp_item_t oldest_rsp;

  int     error_count = 0;
  int     result_count = 0;
  longint cycle_count = 0;
  int     placed_count = 0;
  int     refused_count = 0;
  int     release_count = 0;
  int     missing_count = 0;
  int     compact_count = 0;
  int     noop_count = 0;

  // When set, the sender or the receiver stops idling for a stretch of items.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold = 0;

  first_fit_segment_allocator #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d responses still awaited", $time,
               cycle_count, awaited_rsp.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Unit just past the segment that begins at unit s.
  function automatic int pool_segment_end(input int s);
    int e;
    e = s + 1;
    while (e < CAPACITY && !unit_is_start[e]) e++;
    return e;
  endfunction

  // Applies one accepted item to the predicted pool and returns the response
  // the block owes for it.
  function automatic rsp_item_t predict_response(input req_item_t item);
    rsp_item_t outcome;
    int s;
    int e;
    int cut;
    int i;
    bit placed;
    bit prev_free;
    outcome.status = STAT_OK;
    outcome.start_res = '0;
    case (item.kind)
      KIND_ALLOC: begin
        // First fit: walk segments from unit zero and take the lowest free one
        // that is long enough. A zero size never fits anything.
        outcome.status = STAT_NO_SPACE;
        placed = 1'b0;
        s = 0;
        if (item.size != '0) begin
          while (s < CAPACITY && !placed) begin
            e = pool_segment_end(s);
            if (unit_is_free[s] && (e - s) >= int'(item.size)) begin
              cut = s + int'(item.size);
              unit_is_free[s] = 1'b0;
              // An exact fit leaves nothing to split off.
              if (cut < e) begin
                unit_is_start[cut] = 1'b1;
                unit_is_free[cut] = 1'b1;
              end
              outcome.status = STAT_OK;
              outcome.start_res = START_W'(s);
              placed = 1'b1;
            end else begin
              s = e;
            end
          end
        end
      end
      KIND_FREE: begin
        // Only an exact segment start can be released; neighbors are not merged.
        if (!unit_is_start[item.offset]) begin
          outcome.status = STAT_NOT_FOUND;
        end else begin
          unit_is_free[item.offset] = 1'b1;
        end
      end
      KIND_COMPACT: begin
        // A free segment that follows a free segment is folded into it.
        prev_free = 1'b0;
        for (i = 0; i < CAPACITY; i++) begin
          if (unit_is_start[i]) begin
            if (unit_is_free[i] && prev_free) begin
              unit_is_start[i] = 1'b0;
              unit_is_free[i] = 1'b0;
            end else begin
              prev_free = unit_is_free[i];
            end
          end
        end
      end
      default: begin
      end
    endcase
    return outcome;
  endfunction

  function automatic req_item_t make_item(input logic [KIND_W-1:0] kind, input int size,
                                          input int offset);
    req_item_t item;
    item.kind = kind;
    item.size = SIZE_W'(size);
    item.offset = OFFS_W'(offset);
    return item;
  endfunction

  // Mostly well-formed traffic: small allocations, releases of segments that
  // are really in use, and occasional compactions. The rest is noise: stray
  // offsets, zero and oversized requests, and the unused kind. Fields that an
  // operation ignores carry random bits.
  function automatic req_item_t random_item();
    req_item_t item;
    int roll;
    int pick;
    int i;
    int used_starts [$];
    item.kind = KIND_ALLOC;
    item.size = SIZE_W'($urandom);
    item.offset = OFFS_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        item.size = SIZE_W'($urandom_range(1, 48));
      end else if (pick < 18) begin
        item.size = SIZE_W'($urandom_range(1, CAPACITY));
      end else if (pick == 18) begin
        item.size = SIZE_W'($urandom_range(CAPACITY, 2 ** SIZE_W - 1));
      end else begin
        item.size = '0;
      end
    end else if (roll < 75) begin
      item.kind = KIND_FREE;
      for (i = 0; i < CAPACITY; i++) begin
        if (unit_is_start[i] && !unit_is_free[i]) used_starts.push_back(i);
      end
      if (used_starts.size() > 0) begin
        item.offset = OFFS_W'(used_starts[$urandom_range(0, used_starts.size() - 1)]);
      end
    end else if (roll < 82) begin
      item.kind = KIND_FREE;
    end else if (roll < 92) begin
      item.kind = KIND_COMPACT;
    end else begin
      item.kind = KIND_UNUSED;
    end
    return item;
  endfunction

  // Presents one item after a random idle gap, holds it until the block takes
  // it, and records the response that the item must produce.
  task automatic send_item(input req_item_t item);
    int gap;
    rsp_item_t outcome;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    outcome = predict_response(item);
    awaited_rsp.push_back(outcome);
    case (item.kind)
      KIND_ALLOC: begin
        if (outcome.status == STAT_OK) placed_count++;
        else refused_count++;
      end
      KIND_FREE: begin
        if (outcome.status == STAT_OK) release_count++;
        else missing_count++;
      end
      KIND_COMPACT: compact_count++;
      default: noop_count++;
    endcase
  endtask

  // Holds off new items until every awaited response has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (awaited_rsp.size() != 0);
  endtask

  // Response side: random stalls per result, compared against the oldest
  // prediction field by field.
  always @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      result_count++;
      if (awaited_rsp.size() == 0) begin
        error_count++;
        $display("%0t: unexpected response, none awaited: status %0d start_res %0d", $time,
                 rsp.status, rsp.start_res);
      end else begin
        oldest_rsp = awaited_rsp.pop_front();
        if (rsp.status !== oldest_rsp.status) begin
          error_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   oldest_rsp.status, rsp.status);
        end
        if (rsp.start_res !== oldest_rsp.start_res) begin
          error_count++;
          $display("%0t: start_res mismatch: expected %0d, actual %0d", $time,
                   oldest_rsp.start_res, rsp.start_res);
        end
      end
      rx_hold = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    rsp_ready <= (rx_hold == 0);
  end

  // Size corner cases against an untouched pool: zero, beyond the pool, the
  // widest field value, an exact fit of the whole pool, a request into a full
  // pool, and releasing the same segment twice.
  task automatic test_size_limits();
    send_item(make_item(KIND_ALLOC, 0, 0));
    send_item(make_item(KIND_ALLOC, 2 ** SIZE_W - 1, 0));
    send_item(make_item(KIND_ALLOC, CAPACITY + 1, 0));
    send_item(make_item(KIND_ALLOC, CAPACITY, 0));
    send_item(make_item(KIND_ALLOC, 1, 0));
    send_item(make_item(KIND_FREE, 0, 0));
    send_item(make_item(KIND_FREE, 0, 0));
  endtask

  // Splitting, releasing without merge, and compaction restoring one segment.
  // Releases at units inside a segment and at the last unit must miss.
  task automatic test_split_and_release();
    send_item(make_item(KIND_ALLOC, 1, 0));
    send_item(make_item(KIND_ALLOC, CAPACITY - 1, 0));
    send_item(make_item(KIND_FREE, 0, CAPACITY / 2));
    send_item(make_item(KIND_FREE, 0, 1));
    send_item(make_item(KIND_FREE, 0, 0));
    send_item(make_item(KIND_ALLOC, CAPACITY, 0));
    send_item(make_item(KIND_COMPACT, 0, 0));
    send_item(make_item(KIND_ALLOC, CAPACITY, 0));
    send_item(make_item(KIND_FREE, 0, CAPACITY - 1));
    send_item(make_item(KIND_FREE, 0, 0));
    send_item(make_item(KIND_COMPACT, 0, 0));
  endtask

  // Fields that an operation ignores carry all-ones or alternating patterns,
  // the unused kind must do nothing, and a compact with nothing to merge must
  // leave the pool alone.
  task automatic test_ignored_fields();
    send_item(make_item(KIND_UNUSED, 2 ** SIZE_W - 1, CAPACITY - 1));
    send_item(make_item(KIND_COMPACT, 2 ** SIZE_W - 1, CAPACITY - 1));
    send_item(make_item(KIND_ALLOC, CAPACITY / 2, CAPACITY - 1));
    send_item(make_item(KIND_ALLOC, CAPACITY / 2, 'h2AA));
    send_item(make_item(KIND_FREE, 'h555, CAPACITY / 2));
    send_item(make_item(KIND_FREE, 'h2AA, 0));
    send_item(make_item(KIND_COMPACT, 0, 'h155));
  endtask

  // Random traffic in stretches; each stretch picks whether either side idles,
  // and some stretches end with a full drain of the response channel.
  task automatic test_random_traffic(input int item_total);
    int sent;
    int stretch;
    req_item_t item;
    sent = 0;
    while (sent < item_total) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      stretch = $urandom_range(20, 60);
      repeat (stretch) begin
        if (sent < item_total) begin
          item = random_item();
          send_item(item);
          sent++;
        end
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    int i;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    // Predicted pool after reset: one free segment covering every unit.
    for (i = 0; i < CAPACITY; i++) begin
      unit_is_start[i] = 1'b0;
      unit_is_free[i] = 1'b0;
    end
    unit_is_start[0] = 1'b1;
    unit_is_free[0] = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // The block clears its map after reset; the first item simply waits for
    // req_ready, so no fixed delay is needed here.
    test_size_limits();
    wait_drained();
    test_split_and_release();
    wait_drained();
    test_ignored_fields();
    test_random_traffic(RANDOM_ITEMS);

    // Nothing more is sent. Once the last response is in, give the block more than
    // one full operation time to show any stray response.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d allocations (%0d refused), %0d releases (%0d missed),",
             placed_count + refused_count, refused_count, release_count + missing_count,
             missing_count);
    $display("%0d compactions and %0d no-op items; %0d responses checked in %0d cycles.",
             compact_count, noop_count, result_count, cycle_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ffsa_pkg.sv
hdl/ffsa_map_ram.sv
hdl/first_fit_segment_allocator.sv
sim/tb.sv
